// ===== hdl/mdm_pkg.sv =====
// Shared types, constants and the grading function of the deviation monitor.
// Used by every module under hdl; depends on nothing else.
package mdm_pkg;

    localparam int CHANNELS_MAX         = 8;
    localparam int CHANNEL_COUNT_DEF    = 8;
    localparam int TREND_WINDOW_DEF     = 50;
    localparam int LEVEL_W              = 16;
    localparam int PADDR_W              = 5;
    localparam int PDATA_W              = 32;

    typedef logic signed [LEVEL_W-1:0] t_level;
    typedef logic [LEVEL_W-1:0] t_limit;

    typedef enum logic [1:0] {
        GRADE_NORMAL = 2'd0,
        GRADE_WARN   = 2'd1,
        GRADE_CRIT   = 2'd2
    } t_grade;

    typedef enum logic [1:0] {
        MODE_CHANNEL  = 2'd0,
        MODE_EXPECTED = 2'd1,
        MODE_TREND    = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_MODE        = 3'd0,
        REG_WARN_CH     = 3'd1,
        REG_CRIT_CH     = 3'd2,
        REG_WARN_EXP    = 3'd3,
        REG_CRIT_EXP    = 3'd4,
        REG_SLOPE_LIMIT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic adv;
        logic load;
    } t_pipe_ctl;

    function automatic t_grade f_grade(input t_level v, input t_level ref_v,
                                       input t_limit warn, input t_limit crit);
        logic signed [LEVEL_W:0] d;
        logic [LEVEL_W:0]        m;
        d = (LEVEL_W+1)'(v) - (LEVEL_W+1)'(ref_v);
        m = d[LEVEL_W] ? (LEVEL_W+1)'(-d) : (LEVEL_W+1)'(d);
        if (m > {1'b0, crit}) begin
            return GRADE_CRIT;
        end else if (m > {1'b0, warn}) begin
            return GRADE_WARN;
        end
        return GRADE_NORMAL;
    endfunction

endpackage

// ===== hdl/mdm_median_lane.sv =====
// One channel lane: two-sample history and a registered three-sample median.
// Depends on mdm_pkg.
module mdm_median_lane
    import mdm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_load,
    input  t_level i_sample,
    output t_level o_median
);

    t_level r_h0;
    t_level r_h1;
    t_level r_median;

    function automatic t_level f_median3(input t_level a, input t_level b, input t_level c);
        t_level lo;
        t_level hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            return lo;
        end else if (c >= hi) begin
            return hi;
        end
        return c;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0 <= '0;
            r_h1 <= '0;
        end else if (i_load) begin
            r_h0 <= r_h1;
            r_h1 <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_median <= f_median3(r_h0, r_h1, i_sample);
        end
    end

    assign o_median = r_median;

endmodule

// ===== hdl/mdm_level_merge.sv =====
// Merging stage: sums the lane medians and takes the floored mean over three
// pipeline stages (offset sum, reciprocal multiply, remainder correction).
// Depends on mdm_pkg.
module mdm_level_merge
    import mdm_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic   i_clk,
    input  logic   i_adv,
    input  t_level i_med [CHANNEL_COUNT],
    input  t_level i_exp,
    output t_level o_avg,
    output t_level o_med [CHANNEL_COUNT],
    output t_level o_exp
);

    localparam int U_W = LEVEL_W + $clog2(CHANNEL_COUNT);
    localparam logic [U_W-1:0] OFFSET = U_W'(CHANNEL_COUNT * 32768);
    localparam logic [U_W-1:0] RECIP  = U_W'((64'd1 << U_W) / CHANNEL_COUNT);
    localparam logic [U_W-1:0] NC     = U_W'(CHANNEL_COUNT);

    logic signed [U_W-1:0]  w_sum;
    logic [2*U_W-1:0]       w_prod;
    logic [U_W-1:0]         w_qn;
    logic [U_W-1:0]         w_rem;
    logic [LEVEL_W-1:0]     w_q;

    logic [U_W-1:0]         r_u2;
    logic [U_W-1:0]         r_u3;
    logic [LEVEL_W-1:0]     r_q3;
    t_level                 r_avg4;
    t_level                 r_med2 [CHANNEL_COUNT];
    t_level                 r_med3 [CHANNEL_COUNT];
    t_level                 r_med4 [CHANNEL_COUNT];
    t_level                 r_exp2;
    t_level                 r_exp3;
    t_level                 r_exp4;

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            w_sum = w_sum + U_W'(i_med[c]);
        end
    end

    assign w_prod = (2*U_W)'(r_u2) * (2*U_W)'(RECIP);
    assign w_qn   = U_W'(r_q3) * NC;
    assign w_rem  = r_u3 - w_qn;
    assign w_q    = (w_rem >= NC) ? r_q3 + LEVEL_W'(1) : r_q3;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_u2   <= U_W'(w_sum) + OFFSET;
            r_u3   <= r_u2;
            r_q3   <= w_prod[U_W +: LEVEL_W];
            r_avg4 <= {~w_q[LEVEL_W-1], w_q[LEVEL_W-2:0]};
            r_exp2 <= i_exp;
            r_exp3 <= r_exp2;
            r_exp4 <= r_exp3;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_med2[c] <= i_med[c];
                r_med3[c] <= r_med2[c];
                r_med4[c] <= r_med3[c];
            end
        end
    end

    assign o_avg = r_avg4;
    assign o_med = r_med4;
    assign o_exp = r_exp4;

endmodule

// ===== hdl/mdm_trend.sv =====
// Trend window: running level sums and the division-free least-squares slope
// test at window close, over three pipeline stages. Depends on mdm_pkg.
module mdm_trend
    import mdm_pkg::*;
#(
    parameter int TREND_WINDOW = TREND_WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_level    i_avg,
    input  t_limit    i_slope_limit,
    output logic      o_done,
    output logic      o_found
);

    localparam longint N    = TREND_WINDOW;
    localparam longint SX   = N * (N - 1) / 2;
    localparam longint SXX  = (N - 1) * N * (2 * N - 1) / 6;
    localparam longint DEN  = N * SXX - SX * SX;
    localparam int POS_W    = $clog2(TREND_WINDOW);
    localparam int SL_W     = LEVEL_W + $clog2(TREND_WINDOW);
    localparam int SW_W     = LEVEL_W + 1 + $clog2(SX + 1);
    localparam int NA_W     = SW_W + $clog2(N + 1);
    localparam int NB_W     = SL_W + $clog2(SX + 1);
    localparam int NUM_W    = ((NA_W > NB_W) ? NA_W : NB_W) + 2;
    localparam int LIM_W    = LEVEL_W + $clog2(DEN + 1);
    localparam int CMP_W    = (NUM_W > LIM_W) ? NUM_W : LIM_W;
    localparam logic signed [CMP_W-1:0] N_C   = CMP_W'(N);
    localparam logic signed [CMP_W-1:0] SX_C  = CMP_W'(SX);
    localparam logic [CMP_W-1:0]        DEN_C = CMP_W'(DEN);
    localparam logic [POS_W-1:0]        LAST  = POS_W'(TREND_WINDOW - 1);

    logic [POS_W-1:0]          r_pos;
    logic signed [SL_W-1:0]    r_sl;
    logic signed [SW_W-1:0]    r_sw;
    logic signed [SL_W-1:0]    r_fin_sl;
    logic signed [SW_W-1:0]    r_fin_sw;
    logic                      r_done5;
    logic signed [CMP_W-1:0]   r_nsw6;
    logic signed [CMP_W-1:0]   r_sxsl6;
    logic [CMP_W-1:0]          r_lim6;
    logic                      r_done6;
    logic                      r_done7;
    logic                      r_found7;

    logic signed [POS_W+LEVEL_W:0] w_wprod;
    logic signed [SL_W-1:0]        n_sl;
    logic signed [SW_W-1:0]        n_sw;
    logic                          w_close;
    logic signed [CMP_W-1:0]       w_num;
    logic [CMP_W-1:0]              w_mag;

    assign w_wprod = $signed({1'b0, r_pos}) * i_avg;
    assign n_sl    = r_sl + SL_W'(i_avg);
    assign n_sw    = r_sw + SW_W'(w_wprod);
    assign w_close = (r_pos == LAST);
    assign w_num   = r_nsw6 - r_sxsl6;
    assign w_mag   = w_num[CMP_W-1] ? CMP_W'(-w_num) : CMP_W'(w_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_sl  <= '0;
            r_sw  <= '0;
        end else if (i_ctl.adv && i_ctl.load) begin
            if (w_close) begin
                r_pos <= '0;
                r_sl  <= '0;
                r_sw  <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
                r_sl  <= n_sl;
                r_sw  <= n_sw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_done5  <= i_ctl.load && w_close;
            r_fin_sl <= n_sl;
            r_fin_sw <= n_sw;
            r_nsw6   <= CMP_W'(r_fin_sw) * N_C;
            r_sxsl6  <= CMP_W'(r_fin_sl) * SX_C;
            r_lim6   <= CMP_W'(i_slope_limit) * DEN_C;
            r_done6  <= r_done5;
            r_done7  <= r_done6;
            r_found7 <= r_done6 && (w_mag > r_lim6);
        end
    end

    assign o_done  = r_done7;
    assign o_found = r_found7;

endmodule

// ===== hdl/multichannel_deviation_monitor_unit.sv =====
// Top level of the multichannel deviation monitor: APB registers, lanes,
// grading and the pipeline control. Depends on mdm_pkg, mdm_median_lane,
// mdm_level_merge and mdm_trend.
//
// Usage
//   Input channel: i_valid / o_stall carry one sample set (eight channel
//   samples and the expected value). A transfer happens when i_valid is high
//   and o_stall is low. Output channel: o_valid / i_stall carry one result
//   per input item, in order.
//   Registers sit on the APB port at byte addresses 0x00..0x14; write them
//   only while no item is in flight.
//   Seven register stages lie between the input transfer and o_valid, the
//   first loaded at the transfer edge. One item per cycle is sustained
//   while the receiver does not stall: every lane and merge stage is a
//   registered pipeline stage, and the trend sums take one add per cycle.
//   When the receiver stalls a waiting result, the whole pipeline holds,
//   o_stall rises in the same cycle and the result stays put on the outputs.
//   Reset (synchronous, active low) clears the registers, median histories,
//   held grades, trend window and all valid bits.
module multichannel_deviation_monitor_unit
    import mdm_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int TREND_WINDOW  = TREND_WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic signed [15:0] i_sample_4,
    input  logic signed [15:0] i_sample_5,
    input  logic signed [15:0] i_sample_6,
    input  logic signed [15:0] i_sample_7,
    input  logic signed [15:0] i_expected_speed,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_channel_flags,
    output logic [1:0]         o_expected_state,
    output logic signed [15:0] o_average_level,
    output logic               o_trend_done,
    output logic               o_trend_found
);

    localparam int FLAGS_W = 2 * CHANNELS_MAX;

    logic [1:0] r_mode;
    t_limit     r_warn_ch;
    t_limit     r_crit_ch;
    t_limit     r_warn_exp;
    t_limit     r_crit_exp;
    t_limit     r_slope_limit;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic w_adv;
    logic w_accept;
    logic w_load4;
    logic w_cfg_wr;

    t_level w_sample [CHANNELS_MAX];
    t_level w_med1 [CHANNEL_COUNT];
    t_level w_med4 [CHANNEL_COUNT];
    t_level w_avg4;
    t_level w_exp4;
    t_level r_exp1;

    logic [FLAGS_W-1:0] r_flags_held;
    logic [1:0]         r_exp_held;
    logic [FLAGS_W-1:0] n_flags_held;
    logic [1:0]         n_exp_held;
    logic               w_grade_ch;
    logic               w_grade_exp;
    t_level             w_ch_ref;

    logic [FLAGS_W-1:0] r_s5_flags, r_s6_flags, r_s7_flags;
    logic [1:0]         r_s5_exp, r_s6_exp, r_s7_exp;
    t_level             r_s5_avg, r_s6_avg, r_s7_avg;

    t_pipe_ctl w_trend_ctl;

    // handshake and pipeline advance
    assign o_stall  = r_v7 && i_stall;
    assign w_adv    = !o_stall;
    assign w_accept = i_valid && w_adv;
    assign w_load4  = r_v4 && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= '0;
            r_warn_ch     <= '0;
            r_crit_ch     <= '0;
            r_warn_exp    <= '0;
            r_crit_exp    <= '0;
            r_slope_limit <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_MODE:        r_mode        <= pwdata[1:0];
                REG_WARN_CH:     r_warn_ch     <= pwdata[15:0];
                REG_CRIT_CH:     r_crit_ch     <= pwdata[15:0];
                REG_WARN_EXP:    r_warn_exp    <= pwdata[15:0];
                REG_CRIT_EXP:    r_crit_exp    <= pwdata[15:0];
                REG_SLOPE_LIMIT: r_slope_limit <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:        prdata = PDATA_W'(r_mode);
            REG_WARN_CH:     prdata = PDATA_W'(r_warn_ch);
            REG_CRIT_CH:     prdata = PDATA_W'(r_crit_ch);
            REG_WARN_EXP:    prdata = PDATA_W'(r_warn_exp);
            REG_CRIT_EXP:    prdata = PDATA_W'(r_crit_exp);
            REG_SLOPE_LIMIT: prdata = PDATA_W'(r_slope_limit);
            default:         prdata = '0;
        endcase
    end

    // lanes
    assign w_sample[0] = i_sample_0;
    assign w_sample[1] = i_sample_1;
    assign w_sample[2] = i_sample_2;
    assign w_sample[3] = i_sample_3;
    assign w_sample[4] = i_sample_4;
    assign w_sample[5] = i_sample_5;
    assign w_sample[6] = i_sample_6;
    assign w_sample[7] = i_sample_7;

    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
        mdm_median_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_load   (w_accept),
            .i_sample (w_sample[c]),
            .o_median (w_med1[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_exp1 <= i_expected_speed;
        end
    end

    mdm_level_merge #(
        .CHANNEL_COUNT (CHANNEL_COUNT)
    ) u_merge (
        .i_clk (i_clk),
        .i_adv (w_adv),
        .i_med (w_med1),
        .i_exp (r_exp1),
        .o_avg (w_avg4),
        .o_med (w_med4),
        .o_exp (w_exp4)
    );

    // grading
    assign w_grade_ch  = (r_mode == MODE_CHANNEL) || (r_mode == MODE_TREND);
    assign w_grade_exp = (r_mode == MODE_EXPECTED);
    assign w_ch_ref    = (r_mode == MODE_CHANNEL) ? w_avg4 : w_exp4;

    always_comb begin
        n_flags_held = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            n_flags_held[2*c +: 2] = f_grade(w_med4[c], w_ch_ref, r_warn_ch, r_crit_ch);
        end
        if (!w_grade_ch) begin
            n_flags_held = r_flags_held;
        end
        n_exp_held = w_grade_exp ? f_grade(w_exp4, w_avg4, r_warn_exp, r_crit_exp)
                                 : r_exp_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags_held <= '0;
            r_exp_held   <= GRADE_NORMAL;
        end else if (w_load4) begin
            r_flags_held <= n_flags_held;
            r_exp_held   <= n_exp_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_flags <= n_flags_held;
            r_s5_exp   <= n_exp_held;
            r_s5_avg   <= w_avg4;
            r_s6_flags <= r_s5_flags;
            r_s6_exp   <= r_s5_exp;
            r_s6_avg   <= r_s5_avg;
            r_s7_flags <= r_s6_flags;
            r_s7_exp   <= r_s6_exp;
            r_s7_avg   <= r_s6_avg;
        end
    end

    // trend window
    assign w_trend_ctl.adv  = w_adv;
    assign w_trend_ctl.load = r_v4 && (r_mode == MODE_TREND);

    mdm_trend #(
        .TREND_WINDOW (TREND_WINDOW)
    ) u_trend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_trend_ctl),
        .i_avg         (w_avg4),
        .i_slope_limit (r_slope_limit),
        .o_done        (o_trend_done),
        .o_found       (o_trend_found)
    );

    assign o_valid          = r_v7;
    assign o_channel_flags  = r_s7_flags;
    assign o_expected_state = r_s7_exp;
    assign o_average_level  = r_s7_avg;

endmodule
